>>> hw/rtl/izci_pkg.sv
// Package for the interpolated zero-crossing interval block.
// Holds shared widths, default parameters, the back-end state type and status struct.
// No dependencies.
package izci_pkg;

    // default fixed-point format, unsigned Q24.16
    localparam int FRAC_BITS_DEF = 16;
    localparam int INT_BITS_DEF  = 24;

    // sample and magnitude widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 16;
    localparam int DEN_W    = MAG_W + 1;

    // crossing queue depth
    localparam int QUEUE_DEPTH = 4;

    // back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN,
        ST_HOLD
    } t_back_state;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

>>> hw/rtl/izci_fifo.sv
// Small crossing queue between the front end and the back end.
// Depends on izci_pkg for the status struct.
module izci_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = izci_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [DATA_W-1:0]      i_data,
    input  logic                   i_pop,
    output logic [DATA_W-1:0]      o_data,
    output izci_pkg::t_queue_stat  o_stat
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

>>> hw/rtl/izci_front.sv
// Front end: takes samples, detects sign changes and counts whole samples.
// Depends on izci_pkg; feeds crossing records into izci_fifo.
module izci_front #(
    parameter int FRAC_BITS = izci_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = izci_pkg::INT_BITS_DEF,
    localparam int TOTAL_W  = INT_BITS + FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [izci_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                 o_ready,
    input  izci_pkg::t_queue_stat                i_stat,
    output logic                                 o_push,
    output logic [TOTAL_W-1:0]                   o_acc,
    output logic [izci_pkg::MAG_W-1:0]           o_num,
    output logic [izci_pkg::DEN_W-1:0]           o_den
);
    localparam logic [TOTAL_W-1:0] ONE_Q = TOTAL_W'(1) << FRAC_BITS;
    localparam logic [TOTAL_W-1:0] MAX_Q = '1;

    logic signed [izci_pkg::SAMPLE_W-1:0] r_prev;
    logic [TOTAL_W-1:0]                   r_acc, n_acc;
    logic [izci_pkg::MAG_W-1:0]           prev_mag, curr_mag;
    logic                                 crossing;
    logic                                 take;

    // magnitudes; the most negative sample maps to 0x8000 as unsigned
    assign prev_mag = r_prev[izci_pkg::SAMPLE_W-1] ? (~r_prev + 1'b1) : r_prev;
    assign curr_mag = i_sample[izci_pkg::SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;
    assign crossing = r_prev[izci_pkg::SAMPLE_W-1] != i_sample[izci_pkg::SAMPLE_W-1];

    assign o_ready = !i_stat.full;
    assign take    = i_valid && o_ready;
    assign o_push  = take && crossing;
    assign o_acc   = r_acc;
    assign o_num   = prev_mag;
    assign o_den   = {1'b0, prev_mag} + {1'b0, curr_mag};

    // whole-sample accumulator since last crossing, saturating
    always_comb begin
        n_acc = r_acc;
        if (take) begin
            if (crossing) begin
                n_acc = '0;
            end else if (r_acc > MAX_Q - ONE_Q) begin
                n_acc = MAX_Q;
            end else begin
                n_acc = r_acc + ONE_Q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_acc  <= '0;
        end else begin
            r_acc <= n_acc;
            if (take) begin
                r_prev <= i_sample;
            end
        end
    end

endmodule

>>> hw/rtl/izci_back.sv
// Back end: divides out the crossing fraction one bit a cycle and forms the interval.
// Depends on izci_pkg; pops crossing records from izci_fifo.
module izci_back #(
    parameter int FRAC_BITS = izci_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = izci_pkg::INT_BITS_DEF,
    localparam int TOTAL_W  = INT_BITS + FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  izci_pkg::t_queue_stat      i_stat,
    input  logic [TOTAL_W-1:0]         i_acc,
    input  logic [izci_pkg::MAG_W-1:0] i_num,
    input  logic [izci_pkg::DEN_W-1:0] i_den,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic [TOTAL_W-1:0]         o_interval,
    input  logic                       i_ready
);
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam int SUM_W = TOTAL_W + 2;
    localparam logic [Q_W-1:0]     ONE_F = Q_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0]   MAX_S = {2'b00, {TOTAL_W{1'b1}}};

    izci_pkg::t_back_state r_state, n_state;

    logic [TOTAL_W-1:0]           r_acc;
    logic [izci_pkg::DEN_W-1:0]   r_den;
    logic [izci_pkg::DEN_W-1:0]   r_rem;
    logic [Q_W-1:0]               r_q;
    logic [CNT_W-1:0]             r_cnt;
    logic [Q_W-1:0]               r_base;
    logic [TOTAL_W-1:0]           r_out;

    logic                         int_ge;
    logic [izci_pkg::DEN_W:0]     rem2;
    logic                         step_ge;
    logic [SUM_W-1:0]             sum;

    // integer bit of the quotient: num equals den only when the new sample is zero
    assign int_ge  = {1'b0, i_num} >= i_den;
    // one restoring step
    assign rem2    = {r_rem, 1'b0};
    assign step_ge = rem2 >= {1'b0, r_den};
    // interval = whole samples + carry-in from last crossing + fraction
    assign sum     = {2'b00, r_acc} + SUM_W'(r_base) + SUM_W'(r_q);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            izci_pkg::ST_IDLE: if (!i_stat.empty) n_state = izci_pkg::ST_DIV;
            izci_pkg::ST_DIV:  if (r_cnt == CNT_W'(FRAC_BITS - 1)) n_state = izci_pkg::ST_FIN;
            izci_pkg::ST_FIN:  n_state = izci_pkg::ST_HOLD;
            izci_pkg::ST_HOLD: if (i_ready) n_state = izci_pkg::ST_IDLE;
            default:           n_state = izci_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop   = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            izci_pkg::ST_IDLE: o_pop   = !i_stat.empty;
            izci_pkg::ST_HOLD: o_valid = 1'b1;
            default: begin
                o_pop   = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_interval = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= izci_pkg::ST_IDLE;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == izci_pkg::ST_FIN) begin
                r_base <= ONE_F - r_q;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            izci_pkg::ST_IDLE: begin
                r_acc <= i_acc;
                r_den <= i_den;
                r_rem <= int_ge ? ({1'b0, i_num} - i_den) : {1'b0, i_num};
                r_q   <= Q_W'(int_ge);
                r_cnt <= '0;
            end
            izci_pkg::ST_DIV: begin
                r_rem <= step_ge ? izci_pkg::DEN_W'(rem2 - {1'b0, r_den})
                                 : rem2[izci_pkg::DEN_W-1:0];
                r_q   <= {r_q[Q_W-2:0], step_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            izci_pkg::ST_FIN: begin
                r_out <= (sum > MAX_S) ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

>>> hw/rtl/interpolated_zero_cross_interval.sv
// Top level of the interpolated zero-crossing interval block.
// Depends on izci_pkg, izci_front, izci_fifo and izci_back.
//
//  Channel   Direction  Handshake                           Payload
//  sample    in         i_sample_valid / o_sample_ready     i_sample (s16)
//  result    out        o_result_valid / i_result_ready     o_crossing_interval (u Q24.16)
//
// Samples are taken one per cycle while the crossing queue has room.
// Each crossing takes the back end through idle (pop), the bit-serial restoring
// divider, a final add and the output hold state, so one sample a cycle is sustained
// only while crossings come on average no faster than the back end finishes them.
// Reset is synchronous, active low, and clears the previous sample, running interval and queue.
// A stalled result holds the back end; the front keeps going until the queue fills.
module interpolated_zero_cross_interval #(
    parameter int FRAC_BITS = izci_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = izci_pkg::INT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_sample_valid,
    output logic                                 o_sample_ready,
    input  logic signed [izci_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                 o_result_valid,
    input  logic                                 i_result_ready,
    output logic [INT_BITS+FRAC_BITS-1:0]        o_crossing_interval
);
    localparam int TOTAL_W = INT_BITS + FRAC_BITS;
    localparam int ENTRY_W = TOTAL_W + izci_pkg::MAG_W + izci_pkg::DEN_W;

    izci_pkg::t_queue_stat       stat;
    logic                        push, pop;
    logic [TOTAL_W-1:0]          f_acc, b_acc;
    logic [izci_pkg::MAG_W-1:0]  f_num, b_num;
    logic [izci_pkg::DEN_W-1:0]  f_den, b_den;
    logic [ENTRY_W-1:0]          q_wr, q_rd;

    // sign-change detection and whole-sample counting
    izci_front #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_sample_valid),
        .i_sample (i_sample),
        .o_ready  (o_sample_ready),
        .i_stat   (stat),
        .o_push   (push),
        .o_acc    (f_acc),
        .o_num    (f_num),
        .o_den    (f_den)
    );

    assign q_wr = {f_acc, f_num, f_den};

    // crossing queue
    izci_fifo #(
        .DATA_W (ENTRY_W),
        .DEPTH  (izci_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wr),
        .i_pop   (pop),
        .o_data  (q_rd),
        .o_stat  (stat)
    );

    assign {b_acc, b_num, b_den} = q_rd;

    // fraction divide and interval assembly
    izci_back #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .i_acc      (b_acc),
        .i_num      (b_num),
        .i_den      (b_den),
        .o_pop      (pop),
        .o_valid    (o_result_valid),
        .o_interval (o_crossing_interval),
        .i_ready    (i_result_ready)
    );

endmodule

>>> hw/rtl/izci_checker.sv
// Port-level checker for the interpolated zero-crossing interval block, with its bind.
// Depends on izci_pkg and the top-level port list.
module izci_checker #(
    parameter int OUT_W = izci_pkg::INT_BITS_DEF + izci_pkg::FRAC_BITS_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_sample_ready,
    input logic             o_result_valid,
    input logic             i_result_ready,
    input logic [OUT_W-1:0] o_crossing_interval
);

    // a pending result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=> o_result_valid && $stable(o_crossing_interval))
        else $error("result changed while stalled");

    // no result right out of reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result valid after reset");

    // the queue is empty after reset, so samples are taken
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_sample_ready)
        else $error("sample ready low after reset");

    // a delivered result is never followed by another in the next cycle
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && i_result_ready |=> !o_result_valid)
        else $error("back-to-back results");

endmodule

bind interpolated_zero_cross_interval izci_checker #(
    .OUT_W (INT_BITS + FRAC_BITS)
) u_izci_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_sample_ready      (o_sample_ready),
    .o_result_valid      (o_result_valid),
    .i_result_ready      (i_result_ready),
    .o_crossing_interval (o_crossing_interval)
);

>>> bench/izci_interval_checker.sv
// Checker for the interpolated zero-crossing interval block.
// Watches the sample and result channels and predicts every crossing interval.
// Depends on izci_pkg for widths and default parameters.
module izci_interval_checker #(
    parameter int FRAC_BITS = izci_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS  = izci_pkg::INT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_sample_valid,
    input  logic                                 o_sample_ready,
    input  logic signed [izci_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 o_result_valid,
    input  logic                                 i_result_ready,
    input  logic [INT_BITS+FRAC_BITS-1:0]        o_crossing_interval,
    output int                                   n_pending,
    output int                                   n_fail,
    output int                                   n_results
);

    localparam int          TOTAL_W  = INT_BITS + FRAC_BITS;
    localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
    localparam logic [63:0] MAX_Q    = (64'd1 << TOTAL_W) - 64'd1;

    // predictor state: last sample and the interval running since the last crossing
    logic signed [izci_pkg::SAMPLE_W-1:0] last_sample;
    logic [63:0]                          run_interval;

    // crossing intervals still owed by the block, oldest first
    logic [TOTAL_W-1:0] interval_expected[$];
    logic [TOTAL_W-1:0] interval_want;

    int fail_tally   = 0;
    int result_tally = 0;

    // add two Q values and clamp at the format maximum
    function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > MAX_Q) ? MAX_Q : s;
    endfunction

    // magnitude of a signed sample, 0..32768
    function automatic logic [63:0] sample_mag(input logic signed [izci_pkg::SAMPLE_W-1:0] v);
        int w;
        w = v;
        return (w < 0) ? 64'(-w) : 64'(w);
    endfunction

    // advance the predictor by one accepted sample
    function automatic void predict_crossing(input logic signed [izci_pkg::SAMPLE_W-1:0] cur);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] frac;
        if (last_sample[izci_pkg::SAMPLE_W-1] != cur[izci_pkg::SAMPLE_W-1]) begin
            // sign change: interpolate the crossing inside this sample period
            num  = sample_mag(last_sample);
            den  = num + sample_mag(cur);
            frac = (den != 0) ? ((num << FRAC_BITS) / den) : 64'd0;
            if (frac > ONE_Q) begin
                frac = ONE_Q;
            end
            interval_expected.push_back(TOTAL_W'(clamp_add(run_interval, frac)));
            run_interval = ONE_Q - frac;
        end else begin
            run_interval = clamp_add(run_interval, ONE_Q);
        end
        last_sample = cur;
    endfunction

    // compare each result transaction, then account for each sample transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            last_sample  = '0;
            run_interval = '0;
            interval_expected.delete();
            n_pending <= 0;
        end else begin
            if (o_result_valid && i_result_ready) begin
                result_tally++;
                if (interval_expected.size() == 0) begin
                    $error("crossing_interval: unexpected result, expected none, got %0d",
                           o_crossing_interval);
                    fail_tally++;
                end else begin
                    interval_want = interval_expected.pop_front();
                    if (o_crossing_interval !== interval_want) begin
                        $error("crossing_interval: expected %0d, got %0d",
                               interval_want, o_crossing_interval);
                        fail_tally++;
                    end
                end
            end
            if (i_sample_valid && o_sample_ready) begin
                predict_crossing(i_sample);
            end
            n_pending <= interval_expected.size();
        end
        n_fail    <= fail_tally;
        n_results <= result_tally;
    end

endmodule

>>> bench/tb_top.sv
// Testbench top for the interpolated zero-crossing interval block.
// Drives samples and result backpressure; izci_interval_checker predicts and compares.
// Depends on izci_pkg, interpolated_zero_cross_interval and izci_interval_checker.
module tb_top;

    localparam int FRAC_BITS   = izci_pkg::FRAC_BITS_DEF;
    localparam int INT_BITS    = izci_pkg::INT_BITS_DEF;
    localparam int SW          = izci_pkg::SAMPLE_W;
    localparam int RAND_ITEMS  = 450;
    localparam int DRAIN_WAIT  = izci_pkg::QUEUE_DEPTH * (FRAC_BITS + 3) + 16;
    localparam int CYCLE_LIMIT = 600000;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_sample_valid = 1'b0;
    logic signed [SW-1:0]          i_sample       = '0;
    logic                          i_result_ready = 1'b0;
    logic                          o_sample_ready;
    logic                          o_result_valid;
    logic [INT_BITS+FRAC_BITS-1:0] o_crossing_interval;

    int n_pending;
    int n_fail;
    int n_results;
    int cycle_count = 0;
    int samples_sent = 0;
    bit gaps_on = 1'b1;

    interpolated_zero_cross_interval #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_sample_valid      (i_sample_valid),
        .o_sample_ready      (o_sample_ready),
        .i_sample            (i_sample),
        .o_result_valid      (o_result_valid),
        .i_result_ready      (i_result_ready),
        .o_crossing_interval (o_crossing_interval)
    );

    izci_interval_checker #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) i_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_sample_valid      (i_sample_valid),
        .o_sample_ready      (o_sample_ready),
        .i_sample            (i_sample),
        .o_result_valid      (o_result_valid),
        .i_result_ready      (i_result_ready),
        .o_crossing_interval (o_crossing_interval),
        .n_pending           (n_pending),
        .n_fail              (n_fail),
        .n_results           (n_results)
    );

    // clock, period 2
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // result backpressure: mostly short stalls, a few long ones, some open stretches
    int  stall_left = 0;
    int  stall_pick;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50) begin
                i_result_ready <= 1'b1;
                stall_left = $urandom_range(0, 7);
            end else if (stall_pick < 80) begin
                i_result_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else if (stall_pick < 92) begin
                i_result_ready <= 1'b0;
                stall_left = $urandom_range(10, 40);
            end else begin
                i_result_ready <= 1'b1;
                stall_left = $urandom_range(50, 150);
            end
        end
    end

    // one sample transaction; valid stays up into the next call unless a gap follows
    task automatic send_sample(input logic signed [SW-1:0] v);
        i_sample_valid <= 1'b1;
        i_sample       <= v;
        @(posedge i_clk);
        while (!o_sample_ready) @(posedge i_clk);
        samples_sent++;
    endtask

    // idle cycles after a transaction: mostly none or short, a few long
    task automatic sender_gap();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        len  = 0;
        if (gaps_on) begin
            if (pick >= 60 && pick < 90) begin
                len = $urandom_range(1, 3);
            end else if (pick >= 90) begin
                len = $urandom_range(10, 40);
            end
        end
        if (len > 0) begin
            i_sample_valid <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // wait until every crossing owed by the block has been checked
    task automatic wait_drained();
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
    endtask

    // sample mostly of the requested sign, biased toward extremes, small values and zero
    function automatic logic signed [SW-1:0] pick_sample(input bit neg);
        int pick;
        int m;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return SW'($urandom());
        end
        case (pick)
            1: begin
                m = neg ? 32768 : 32767;
            end
            2: begin
                m = $urandom_range(1, 4);
            end
            3: begin
                m = neg ? 1 : 0;
            end
            default: begin
                m = neg ? $urandom_range(1, 32768) : $urandom_range(0, 32767);
            end
        endcase
        return neg ? SW'(-m) : SW'(m);
    endfunction

    logic signed [SW-1:0] directed_set[$] = '{
        // negative first sample against the reset value: crossing at fraction 0
        -16'sd1, -16'sd32768,
        // zero after a negative sample: crossing at exactly 1.0
        16'sd0, 16'sd32767,
        // full-scale swings both ways, then small steps around zero
        -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1,
        // small magnitudes and repeated zeros, then full-scale repeats and mid-range values
        -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd5, -16'sd5, 16'sd32767, 16'sd32767,
        -16'sd32768, -16'sd32768, -16'sd2, 16'sd3, -16'sd12345, 16'sd23456
    };

    initial begin
        bit   want_neg;
        int   run_left;
        int   idx;
        logic signed [SW-1:0] v;

        // reset
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sequence
        foreach (directed_set[k]) begin
            send_sample(directed_set[k]);
            sender_gap();
        end

        // random runs of one sign broken by crossings, with some noise
        want_neg = i_sample[SW-1];
        run_left = 0;
        for (idx = 0; idx < RAND_ITEMS; idx++) begin
            if (idx % 64 == 0) begin
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (idx == RAND_ITEMS / 2) begin
                i_sample_valid <= 1'b0;
                wait_drained();
            end
            if (run_left == 0) begin
                want_neg = ~want_neg;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 7);
            end
            v = pick_sample(want_neg);
            send_sample(v);
            want_neg = v[SW-1];
            run_left--;
            sender_gap();
        end
        i_sample_valid <= 1'b0;

        // drain and watch for stray results
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d samples (directed extremes, then random sign runs with noise),",
                 samples_sent);
        $display("checked %0d crossing intervals under random stalls on both channels.",
                 n_results);
        if (n_fail == 0 && n_pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/izci_pkg.sv
hw/rtl/izci_fifo.sv
hw/rtl/izci_front.sv
hw/rtl/izci_back.sv
hw/rtl/interpolated_zero_cross_interval.sv
hw/rtl/izci_checker.sv
bench/izci_interval_checker.sv
bench/tb_top.sv
